// File: hdl/lkvt_pkg.sv
// Shared types and constants for the linear key-value table.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package lkvt_pkg;

	localparam int CNT_W = 5;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_LOOKUP = 2'd1;
	localparam logic [1:0] MODE_DELETE = 2'd2;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] key;
		logic [31:0]        value_word;
	} in_item_t;

	typedef struct packed {
		logic             success;
		logic [31:0]      read_value;
		logic [CNT_W-1:0] entry_count;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_SHIFT,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic shift;
		logic shift_start;
		logic wr_hit;
		logic append;
		logic dec;
		logic set_ok;
		logic take_val;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic       hit;
		logic       drained;
		logic       room;
		logic       out_free;
		logic [1:0] mode;
	} sts_t;

endpackage
`default_nettype wire

// File: hdl/lkvt_ctrl.sv
// Sequencer for the key-value table: decode, scan, shift and result hand-off.
// Depends on lkvt_pkg for the state, command and status types.
`default_nettype none
module lkvt_ctrl
	import lkvt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.mode == MODE_INSERT) begin
					state_d = sts.room ? ST_SCAN : ST_FIN;
				end else if (sts.mode == MODE_LOOKUP || sts.mode == MODE_DELETE) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_SCAN: begin
				if (sts.hit) begin
					if (sts.mode == MODE_INSERT) begin
						cmd.wr_hit = 1'b1;
						cmd.set_ok = 1'b1;
						state_d    = ST_FIN;
					end else if (sts.mode == MODE_LOOKUP) begin
						cmd.take_val = 1'b1;
						cmd.set_ok   = 1'b1;
						state_d      = ST_FIN;
					end else begin
						cmd.shift_start = 1'b1;
						state_d         = ST_SHIFT;
					end
				end else if (sts.drained) begin
					// no match: an insert appends, anything else fails
					if (sts.mode == MODE_INSERT) begin
						cmd.append = 1'b1;
						cmd.set_ok = 1'b1;
					end
					state_d = ST_FIN;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				if (sts.drained) begin
					cmd.dec    = 1'b1;
					cmd.set_ok = 1'b1;
					state_d    = ST_FIN;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: hdl/lkvt_dpath.sv
// Datapath of the key-value table: key and value memories, scan pointer,
// entry count, limit register and result register. Depends on lkvt_pkg.
`default_nettype none
module lkvt_dpath
	import lkvt_pkg::*;
#(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cmd_t       cmd,
	output sts_t            sts,
	input  wire in_item_t   in_item,
	input  wire logic       cfg_valid,
	input  wire logic [CNT_W-1:0] capacity_limit,
	input  wire logic       out_ready,
	output logic            out_valid,
	output out_item_t       out_item
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CAP = (MAX_ENTRIES < 31) ? MAX_ENTRIES : 31;
	localparam logic [CNT_W-1:0] CAP_LIM = CNT_W'(CAP);

	logic signed [31:0] key_mem [MAX_ENTRIES];
	logic [31:0]        val_mem [MAX_ENTRIES];

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] limit_q;
	logic             rv_s1;
	logic [CNT_W-1:0] addr_s1;
	logic signed [31:0] key_rd_s1;
	logic [31:0]      val_rd_s1;

	logic [1:0]         mode_q;
	logic signed [31:0] key_q;
	logic [31:0]        value_q;
	logic               ok_q;
	logic [31:0]        rd_q;

	logic             out_valid_q;
	out_item_t        out_q;

	logic [CNT_W-1:0] eff_lim;
	logic             rd_en;
	logic             key_we;
	logic             val_we;
	logic [CNT_W-1:0] wa;
	logic signed [31:0] wk;
	logic [31:0]      wv;

	assign eff_lim = (limit_q > CAP_LIM) ? CAP_LIM : limit_q;
	assign rd_en   = cmd.step && (ptr_q < cnt_q);

	assign sts.hit      = rv_s1 && (key_rd_s1 == key_q);
	assign sts.drained  = !rv_s1 && (ptr_q >= cnt_q);
	assign sts.room     = cnt_q < eff_lim;
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.mode     = mode_q;

	// write port: append, in-place update or one step of the delete shift
	always_comb begin
		key_we = 1'b0;
		val_we = 1'b0;
		wa     = addr_s1;
		wk     = key_rd_s1;
		wv     = val_rd_s1;
		if (cmd.append) begin
			key_we = 1'b1;
			val_we = 1'b1;
			wa     = cnt_q;
			wk     = key_q;
			wv     = value_q;
		end else if (cmd.wr_hit) begin
			val_we = 1'b1;
			wv     = value_q;
		end else if (cmd.shift && rv_s1) begin
			key_we = 1'b1;
			val_we = 1'b1;
			wa     = addr_s1 - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			key_rd_s1 <= key_mem[AW'(ptr_q)];
			val_rd_s1 <= val_mem[AW'(ptr_q)];
			addr_s1   <= ptr_q;
		end
		if (key_we) begin
			key_mem[AW'(wa)] <= wk;
		end
		if (val_we) begin
			val_mem[AW'(wa)] <= wv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ptr_q       <= '0;
			rv_s1       <= 1'b0;
			limit_q     <= CNT_W'(16);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				limit_q <= capacity_limit;
			end
			if (cmd.load) begin
				ptr_q <= '0;
				rv_s1 <= 1'b0;
			end else if (cmd.shift_start) begin
				// resume reading just past the removed entry
				ptr_q <= addr_s1 + CNT_W'(1);
				rv_s1 <= 1'b0;
			end else if (cmd.step) begin
				rv_s1 <= rd_en;
				if (rd_en) begin
					ptr_q <= ptr_q + CNT_W'(1);
				end
			end
			if (cmd.append) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.dec) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= in_item.mode;
			key_q   <= in_item.key;
			value_q <= in_item.value_word;
			ok_q    <= 1'b0;
			rd_q    <= '0;
		end else begin
			if (cmd.set_ok) begin
				ok_q <= 1'b1;
			end
			if (cmd.take_val) begin
				rd_q <= val_rd_s1;
			end
		end
		if (cmd.finish) begin
			out_q.success     <= ok_q;
			out_q.read_value  <= rd_q;
			out_q.entry_count <= cnt_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP_LIM)
		else $error("entry count beyond usable depth");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rv_s1 |-> addr_s1 < cnt_q)
		else $error("scan read beyond held entries");

	a_insert_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && mode_q == MODE_INSERT && ok_q |-> cnt_q <= eff_lim)
		else $error("insert succeeded past the limit");

	a_no_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !out_valid_q || out_ready)
		else $error("result register overwritten");

endmodule
`default_nettype wire

// File: hdl/linear_key_value_table_top.sv
// Linear-search key-value table, one item in flight. A refused insert or an unused mode goes
// from decode straight to the result; an insert or lookup scans the held entries and
// stops at a match; a delete scans to the match, then moves each later entry down one
// per cycle. A result still held in the output register stalls the finish.
// Reset clears the entry count, sets the limit to 16, empties the output register.
`default_nettype none
module linear_key_value_table_top
	import lkvt_pkg::*;
#(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire in_item_t         in_item,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output out_item_t             out_item,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CNT_W-1:0] capacity_limit
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	lkvt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lkvt_dpath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_item        (in_item),
		.cfg_valid      (cfg_valid),
		.capacity_limit (capacity_limit),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.out_item       (out_item)
	);

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the linear key-value table: directed table, then random phases.
// Depends on lkvt_pkg and linear_key_value_table_top; scores against table model or typed rows.
`default_nettype none
module testbench;
	import lkvt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int         MAX_ENTRIES  = 16;
	localparam int         IDLE_LIMIT   = 2000;
	localparam int         PHASE_ITEMS  = 175;
	localparam int         NUM_PHASES   = 10;
	localparam int         POOL_SIZE    = 24;
	localparam logic [1:0] MODE_UNUSED  = 2'd3;

	typedef struct packed {
		bit          is_cfg;
		logic [4:0]  cfg;
		logic [1:0]  mode;
		logic [31:0] key;
		logic [31:0] value_word;
		bit          typed;
		logic        success;
		logic [31:0] read_value;
		logic [4:0]  entry_count;
	} dir_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic [4:0] capacity_limit = 5'd16;

	// table model
	logic [31:0] key_model   [MAX_ENTRIES];
	logic [31:0] value_model [MAX_ENTRIES];
	int          held_count = 0;
	logic [4:0]  cap_limit = 5'd16;

	out_item_t   expected_results [$];
	logic [31:0] key_pool [POOL_SIZE];
	int          mismatches = 0;
	int          idle_cycles = 0;
	int          tx_calm = 0;
	int          rx_calm = 0;
	int          rx_stall = 0;

	dir_row_t directed_rows [29] = '{
		'{1'b0, 5'd0,  MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 5'd0},
		'{1'b0, 5'd0,  MODE_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 5'd0},
		'{1'b0, 5'd0,  MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 5'd0},
		'{1'b0, 5'd0,  MODE_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0, 5'd1},
		'{1'b0, 5'd0,  MODE_INSERT, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h0, 5'd2},
		'{1'b0, 5'd0,  MODE_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF, 5'd2},
		'{1'b0, 5'd0,  MODE_LOOKUP, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0, 5'd2},
		'{1'b0, 5'd0,  MODE_INSERT, 32'h8000_0000, 32'h1234_5678, 1'b1, 1'b1, 32'h0, 5'd2},
		'{1'b0, 5'd0,  MODE_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h1234_5678, 5'd2},
		'{1'b0, 5'd0,  MODE_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b0, 1'b0, 32'h0, 5'd0},
		'{1'b0, 5'd0,  MODE_INSERT, 32'h0000_0000, 32'h0000_0001, 1'b0, 1'b0, 32'h0, 5'd0},
		'{1'b0, 5'd0,  MODE_DELETE, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h0, 5'd3},
		'{1'b0, 5'd0,  MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 5'd0},
		'{1'b0, 5'd0,  MODE_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 5'd3},
		'{1'b0, 5'd0,  MODE_UNUSED, 32'h7FFF_FFFF, 32'h5A5A_5A5A, 1'b1, 1'b0, 32'h0, 5'd3},
		'{1'b0, 5'd0,  MODE_DELETE, 32'h5555_5555, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 5'd3},
		'{1'b1, 5'd3,  MODE_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 5'd0},
		'{1'b0, 5'd0,  MODE_INSERT, 32'hFFFF_FFFF, 32'h0000_0042, 1'b1, 1'b0, 32'h0, 5'd3},
		'{1'b0, 5'd0,  MODE_INSERT, 32'h0000_0007, 32'h0000_0042, 1'b1, 1'b0, 32'h0, 5'd3},
		'{1'b1, 5'd0,  MODE_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 5'd0},
		'{1'b0, 5'd0,  MODE_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0, 5'd2},
		'{1'b0, 5'd0,  MODE_INSERT, 32'h0000_0007, 32'h0000_0042, 1'b1, 1'b0, 32'h0, 5'd2},
		'{1'b0, 5'd0,  MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 5'd0},
		'{1'b1, 5'd31, MODE_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 5'd0},
		'{1'b0, 5'd0,  MODE_INSERT, 32'h0000_0007, 32'h0BAD_F00D, 1'b1, 1'b1, 32'h0, 5'd3},
		'{1'b1, 5'd1,  MODE_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 5'd0},
		'{1'b0, 5'd0,  MODE_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 5'd0},
		'{1'b0, 5'd0,  MODE_DELETE, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0, 5'd2},
		'{1'b1, 5'd16, MODE_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 5'd0}
	};

	linear_key_value_table_top #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_item        (in_item),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_item       (out_item),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.capacity_limit (capacity_limit)
	);

	always #2 clk = ~clk;

	// Find the lowest held index with a matching key, then apply the operation to the model table.
	function automatic out_item_t apply_table_op(in_item_t it);
		out_item_t res;
		int        hit;
		int        lim;
		int        i;
		res = '0;
		hit = held_count;
		lim = (cap_limit > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap_limit);
		for (i = held_count - 1; i >= 0; i--)
			if (key_model[i] == it.key)
				hit = i;
		case (it.mode)
			MODE_INSERT: begin
				if (held_count < lim) begin
					if (hit < held_count) begin
						value_model[hit] = it.value_word;
					end else begin
						key_model[held_count]   = it.key;
						value_model[held_count] = it.value_word;
						held_count++;
					end
					res.success = 1'b1;
				end
			end
			MODE_LOOKUP: begin
				if (hit < held_count) begin
					res.success    = 1'b1;
					res.read_value = value_model[hit];
				end
			end
			MODE_DELETE: begin
				if (hit < held_count) begin
					for (i = hit; i + 1 < held_count; i++) begin
						key_model[i]   = key_model[i + 1];
						value_model[i] = value_model[i + 1];
					end
					held_count--;
					res.success = 1'b1;
				end
			end
			default: ;
		endcase
		res.entry_count = 5'(held_count);
		return res;
	endfunction

	// Mostly short gaps, a few long ones, and now and then a calm stretch with none.
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Prefer keys already held so that hits, updates and deletes are frequent.
	function automatic logic [31:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (held_count > 0 && r < 55)
			return key_model[$urandom_range(0, held_count - 1)];
		if (r < 92)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		return $urandom();
	endfunction

	function automatic in_item_t make_request(int ins_pct, int del_pct);
		in_item_t it;
		int       r;
		r = $urandom_range(0, 99);
		if (r < ins_pct)
			it.mode = MODE_INSERT;
		else if (r < ins_pct + del_pct)
			it.mode = MODE_DELETE;
		else if (r < 95)
			it.mode = MODE_LOOKUP;
		else
			it.mode = MODE_UNUSED;
		it.key        = pick_key();
		it.value_word = $urandom();
		return it;
	endfunction

	task automatic refresh_pool();
		int i;
		for (i = 0; i < POOL_SIZE; i++)
			case (i)
				0:       key_pool[i] = 32'h8000_0000;
				1:       key_pool[i] = 32'h7FFF_FFFF;
				2:       key_pool[i] = 32'h0000_0000;
				3:       key_pool[i] = 32'hFFFF_FFFF;
				default: key_pool[i] = $urandom();
			endcase
	endtask

	// Entered and left at a falling edge.
	task automatic wait_drained();
		while (expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_capacity(logic [4:0] lim);
		wait_drained();
		cfg_valid      = 1'b1;
		capacity_limit = lim;
		do
			@(posedge clk);
		while (!cfg_ready);
		cap_limit = lim;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_request(in_item_t it, bit use_typed, out_item_t typed_res);
		out_item_t predicted;
		int        gap;
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_item  = it;
		do
			@(posedge clk);
		while (!in_ready);
		predicted = apply_table_op(it);
		expected_results.push_back(use_typed ? typed_res : predicted);
		@(negedge clk);
		// drop valid once the transaction is taken; the next call raises it again
		in_valid = 1'b0;
	endtask

	// Receiver back-pressure.
	initial begin
		forever begin
			@(negedge clk);
			if (rx_stall > 0) begin
				rx_stall--;
				out_ready = 1'b0;
			end else begin
				out_ready = 1'b1;
				rx_stall  = pick_gap(rx_calm);
			end
		end
	end

	// Score each result transaction against the oldest expectation.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: success=%0b read_value=%h entry_count=%0d",
						out_item.success, out_item.read_value, out_item.entry_count);
			end else begin
				want = expected_results.pop_front();
				if (out_item.success !== want.success ||
				    out_item.read_value !== want.read_value ||
				    out_item.entry_count !== want.entry_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0b %h %0d, got %0b %h %0d",
							want.success, want.read_value, want.entry_count,
							out_item.success, out_item.read_value,
							out_item.entry_count);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
		    (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("testbench: done, errors");
		$finish;
	end

	initial begin
		int         row;
		int         ph;
		int         n;
		int         ins_pct;
		int         del_pct;
		logic [4:0] lim;
		out_item_t  typed_res;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (row = 0; row < $size(directed_rows); row++) begin
			if (directed_rows[row].is_cfg) begin
				write_capacity(directed_rows[row].cfg);
			end else begin
				typed_res.success     = directed_rows[row].success;
				typed_res.read_value  = directed_rows[row].read_value;
				typed_res.entry_count = directed_rows[row].entry_count;
				send_request('{directed_rows[row].mode, directed_rows[row].key,
					directed_rows[row].value_word}, directed_rows[row].typed, typed_res);
			end
		end

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0:       lim = 5'd16;
				1:       lim = 5'd31;
				2:       lim = 5'd0;
				3:       lim = 5'd1;
				4:       lim = 5'd8;
				5:       lim = 5'd2;
				6:       lim = 5'd15;
				7:       lim = 5'd17;
				8:       lim = 5'($urandom_range(0, 31));
				default: lim = 5'd16;
			endcase
			write_capacity(lim);
			refresh_pool();
			ins_pct = $urandom_range(25, 55);
			del_pct = $urandom_range(15, 30);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// in every third phase, hold the sender mid-phase until the block has emptied
				if (ph % 3 == 0 && n == PHASE_ITEMS / 2)
					wait_drained();
				send_request(make_request(ins_pct, del_pct), 1'b0, '0);
			end
		end
		in_valid = 1'b0;

		wait_drained();
		repeat (60) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
`default_nettype wire

// File: sim.f
hdl/lkvt_pkg.sv
hdl/lkvt_ctrl.sv
hdl/lkvt_dpath.sv
hdl/linear_key_value_table_top.sv
tb/testbench.sv
